@@ hw/rtl/dsjq_pkg.sv @@
package dsjq_pkg;

    // fixed field widths of the request and result channels
    localparam int OP_W    = 2;
    localparam int DIN_W   = 16;
    localparam int ELAP_W  = 16;
    localparam int JOB_W   = 16;
    localparam int DOUT_W  = 16;
    localparam int OCC_W   = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic rem;
        logic tick;
    } cell_ctl_t;

endpackage

@@ hw/rtl/delay_sorted_job_queue_core.sv @@
// Sorted job queue of QUEUE_DEPTH entries held in a chain of slot cells, smallest remaining
// delay at the head and equal delays in arrival order. Each request is insert (the job gets
// the next number of a wrapping 16-bit counter), remove (pops the head and returns its number
// and remaining delay) or tick (subtracts elapsed from every delay, flooring at zero). Every
// request gives exactly one result in the cycle after it is taken; an insert on a full
// queue, a remove on an empty one and the unused code fail with ok low and change nothing.
// All cells shift, load or subtract together in the same cycle, so one request is taken
// per cycle unless a result is held; the single result register sets that figure, and
// in_stall rises only while a result is held by out_stall. No start-up pass is needed.
module delay_sorted_job_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int DELAY_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [dsjq_pkg::OP_W-1:0]    operation,
    input  logic [dsjq_pkg::DIN_W-1:0]   delay_in,
    input  logic [dsjq_pkg::ELAP_W-1:0]  elapsed,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         ok,
    output logic [dsjq_pkg::JOB_W-1:0]   job_number,
    output logic [dsjq_pkg::DOUT_W-1:0]  delay_left,
    output logic [dsjq_pkg::OCC_W-1:0]   occupancy
);

    localparam int JOB_W  = dsjq_pkg::JOB_W;
    localparam int DOUT_W = dsjq_pkg::DOUT_W;
    localparam int OCC_W  = dsjq_pkg::OCC_W;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      ok_reg;
    logic                      ok_next;
    logic [JOB_W-1:0]          job_reg;
    logic [JOB_W-1:0]          job_next;
    logic [DOUT_W-1:0]         delay_left_reg;
    logic [DOUT_W-1:0]         delay_left_next;
    logic [OCC_W-1:0]          occupancy_reg;
    logic [OCC_W-1:0]          occupancy_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [JOB_W-1:0]          next_job_reg;
    logic [JOB_W-1:0]          next_job_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic [DELAY_BITS-1:0]     new_delay;
    dsjq_pkg::cell_ctl_t       ctl;

    logic [DELAY_BITS-1:0]     chain_delay [QUEUE_DEPTH];
    logic [JOB_W-1:0]          chain_job   [QUEUE_DEPTH];
    logic                      chain_after [QUEUE_DEPTH];
    logic                      occupied    [QUEUE_DEPTH];

    // request handshake: the result register frees up when taken
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign new_delay = DELAY_BITS'(delay_in);

    // operation decode and result values
    always_comb
    begin
        ctl             = '0;
        ok_next         = 1'b0;
        job_next        = '0;
        delay_left_next = '0;
        count_next      = count_reg;
        next_job_next   = next_job_reg;
        unique case (operation)
            dsjq_pkg::OP_INSERT:
            begin
                if (!full)
                begin
                    ctl.ins       = accept;
                    ok_next       = 1'b1;
                    job_next      = next_job_reg;
                    count_next    = count_reg + 1'b1;
                    next_job_next = next_job_reg + 1'b1;
                end
            end
            dsjq_pkg::OP_REMOVE:
            begin
                if (!empty)
                begin
                    ctl.rem         = accept;
                    ok_next         = 1'b1;
                    job_next        = chain_job[0];
                    delay_left_next = DOUT_W'(chain_delay[0]);
                    count_next      = count_reg - 1'b1;
                end
            end
            dsjq_pkg::OP_TICK:
            begin
                ctl.tick = accept;
                ok_next  = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
        occupancy_next = OCC_W'(count_next);
        out_valid_next = accept || in_stall;
    end

    // chain of slot cells
    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic                  left_after;
            logic [DELAY_BITS-1:0] left_delay;
            logic [JOB_W-1:0]      left_job;
            logic [DELAY_BITS-1:0] right_delay;
            logic [JOB_W-1:0]      right_job;

            assign occupied[i] = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign left_after = 1'b1;
                assign left_delay = '0;
                assign left_job   = '0;
            end
            else
            begin : g_mid
                assign left_after = chain_after[i-1];
                assign left_delay = chain_delay[i-1];
                assign left_job   = chain_job[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_delay = '0;
                assign right_job   = '0;
            end
            else
            begin : g_body
                assign right_delay = chain_delay[i+1];
                assign right_job   = chain_job[i+1];
            end

            dsjq_cell #(
                .DELAY_BITS (DELAY_BITS)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (occupied[i]),
                .new_delay   (new_delay),
                .new_job     (next_job_reg),
                .elapsed     (elapsed),
                .left_after  (left_after),
                .left_delay  (left_delay),
                .left_job    (left_job),
                .right_delay (right_delay),
                .right_job   (right_job),
                .after       (chain_after[i]),
                .delay       (chain_delay[i]),
                .job         (chain_job[i])
            );
        end
    endgenerate

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            next_job_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg    <= count_next;
                next_job_reg <= next_job_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg         <= ok_next;
            job_reg        <= job_next;
            delay_left_reg <= delay_left_next;
            occupancy_reg  <= occupancy_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign job_number = job_reg;
    assign delay_left = delay_left_reg;
    assign occupancy  = occupancy_reg;

    // fill level never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue fill level above depth");

    // a shown result reports the current fill level
    a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> occupancy_reg == OCC_W'(count_reg))
        else $error("occupancy differs from fill level");

    // an accepted insert into a non-full queue succeeds and grows the queue by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == dsjq_pkg::OP_INSERT && !full)
        |=> (ok_reg && count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not add an entry");

    // a remove on an empty queue fails and leaves it empty
    a_remove_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == dsjq_pkg::OP_REMOVE && empty)
        |=> (!ok_reg && count_reg == '0))
        else $error("remove on empty queue misreported");

endmodule

@@ hw/rtl/dsjq_cell.sv @@
module dsjq_cell #(
    parameter int DELAY_BITS = 16
) (
    input  logic                       clk,
    input  dsjq_pkg::cell_ctl_t        ctl,
    input  logic                       occupied,
    input  logic [DELAY_BITS-1:0]      new_delay,
    input  logic [dsjq_pkg::JOB_W-1:0] new_job,
    input  logic [dsjq_pkg::ELAP_W-1:0] elapsed,
    input  logic                       left_after,
    input  logic [DELAY_BITS-1:0]      left_delay,
    input  logic [dsjq_pkg::JOB_W-1:0] left_job,
    input  logic [DELAY_BITS-1:0]      right_delay,
    input  logic [dsjq_pkg::JOB_W-1:0] right_job,
    output logic                       after,
    output logic [DELAY_BITS-1:0]      delay,
    output logic [dsjq_pkg::JOB_W-1:0] job
);

    localparam int CMP_W = (DELAY_BITS > dsjq_pkg::ELAP_W) ? DELAY_BITS : dsjq_pkg::ELAP_W;

    logic [DELAY_BITS-1:0]      delay_reg;
    logic [DELAY_BITS-1:0]      delay_next;
    logic [dsjq_pkg::JOB_W-1:0] job_reg;
    logic [dsjq_pkg::JOB_W-1:0] job_next;
    logic [CMP_W-1:0]           cur_ext;
    logic [CMP_W-1:0]           el_ext;
    logic [CMP_W-1:0]           diff;

    // new entry goes behind this one when this one is held and not larger
    assign after = occupied && (delay_reg <= new_delay);

    // floored subtraction of the elapsed ticks
    assign cur_ext = CMP_W'(delay_reg);
    assign el_ext  = CMP_W'(elapsed);
    assign diff    = (cur_ext > el_ext) ? (cur_ext - el_ext) : '0;

    // keep, shift toward the tail, take the new entry, shift toward the head, or subtract elapsed
    always_comb
    begin
        delay_next = delay_reg;
        job_next   = job_reg;
        if (ctl.ins)
        begin
            if (!after)
            begin
                if (left_after)
                begin
                    delay_next = new_delay;
                    job_next   = new_job;
                end
                else
                begin
                    delay_next = left_delay;
                    job_next   = left_job;
                end
            end
        end
        else if (ctl.rem)
        begin
            delay_next = right_delay;
            job_next   = right_job;
        end
        else if (ctl.tick)
        begin
            delay_next = DELAY_BITS'(diff);
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        delay_reg <= delay_next;
        job_reg   <= job_next;
    end

    assign delay = delay_reg;
    assign job   = job_reg;

endmodule
